// File: rtl/ipt_pkg.sv
// ----------------------------------------------------------------------------
// ipt_pkg
// Shared types and constants for the id pair table: action and status codes,
// field widths of the request and response beats, and the stored pair.
// ----------------------------------------------------------------------------
package ipt_pkg;

  localparam int unsigned ID_W  = 32;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_FIND_T = 2'd1,
    ACT_FIND_R = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0] transform_id;
    logic [ID_W-1:0] render_id;
  } pair_t;

endpackage

// File: rtl/ipt_if.sv
// ----------------------------------------------------------------------------
// ipt_if
// Request and response channels of the id pair table, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ipt_req_if import ipt_pkg::*; ();
  logic              valid;
  logic              ready;
  action_e           action;
  logic [ID_W-1:0]   transform_id;
  logic [ID_W-1:0]   render_id;

  modport source (output valid, action, transform_id, render_id, input ready);
  modport sink   (input valid, action, transform_id, render_id, output ready);
endinterface

interface ipt_rsp_if import ipt_pkg::*; ();
  logic              valid;
  logic              ready;
  status_e           status;
  logic [IDX_W-1:0]  entry_index;
  logic [ID_W-1:0]   paired_id;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, status, entry_index, paired_id, entry_count,
                  input ready);
  modport sink   (input valid, status, entry_index, paired_id, entry_count,
                  output ready);
endinterface

// File: rtl/id_pair_table_swap_remove_top.sv
// ----------------------------------------------------------------------------
// id_pair_table_swap_remove_top
// Dense table of (transform id, render id) pairs with add, find and
// swap-remove, kept in one synchronous single-read-port memory.
// ----------------------------------------------------------------------------
// The block holds up to TABLE_DEPTH pairs packed at indices 0 to count-1 and
// handles one request beat at a time, returning exactly one response beat per
// request. Add writes the pair at index count in the cycle it is accepted, and
// its response beat goes through ST_RESP into the output register. The finds
// and remove walk the table from index 0 upward through the memory's single
// read port, one entry per cycle, and stop at the lowest match or report a
// miss after the last pair; an empty table misses without a scan. A remove
// that hits below the last entry then passes through ST_LAST to read the last
// pair and ST_MOVE to write it into the freed slot, so the longest request is
// a remove that hits the next-to-last entry of a full table. The scan rate is
// set by the one-entry-per-cycle read port. A response waits in an output
// register until the sink takes it, and the next request is accepted at the
// earliest at the edge after the previous one has been handed to that
// register, so the block takes no new request until the previous response
// has been handed to the output register. Index and count in the response
// are the low 10 and 11 bits. There is no clearing pass after reset: only
// entries below the count are read.
module id_pair_table_swap_remove_top import ipt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ipt_req_if.sink     req_i,
  ipt_rsp_if.source   rsp_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_LAST = 5'b00100,
    ST_MOVE = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     cmp_idx_q, cmp_idx_d;
  action_e           act_q, act_d;
  logic [ID_W-1:0]   tid_q, tid_d;
  logic [ID_W-1:0]   rid_q, rid_d;
  status_e           res_sts_q, res_sts_d;
  logic [IW-1:0]     res_idx_q, res_idx_d;
  logic [ID_W-1:0]   res_other_q, res_other_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_sts_q, out_sts_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [ID_W-1:0]   out_other_q, out_other_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  // Pair memory: one write port, one registered read port.
  pair_t             mem_q [TABLE_DEPTH];
  pair_t             rd_data_q;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  pair_t             mem_wdata;

  logic              key_hit;
  logic              at_last;
  logic              out_free;

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_sts_q;
  assign rsp_o.entry_index = out_idx_q;
  assign rsp_o.paired_id   = out_other_q;
  assign rsp_o.entry_count = out_cnt_q;

  // The output register is free when empty or drained in this cycle.
  assign out_free = !out_valid_q || rsp_o.ready;

  // Compare the entry whose data is on the read port against the search key.
  assign key_hit = (act_q == ACT_FIND_R) ? (rd_data_q.render_id == rid_q)
                                         : (rd_data_q.transform_id == tid_q);
  assign at_last = (CW'(cmp_idx_q) == (cnt_q - CW'(1)));

  // Read address: entry 0 on accept, next entry while scanning, last entry
  // before a swap.
  always_comb begin
    case (state_q)
      ST_SCAN: rd_addr = IW'(cmp_idx_q + 1'b1);
      ST_LAST: rd_addr = IW'(cnt_q - CW'(1));
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmp_idx_d   = cmp_idx_q;
    act_d       = act_q;
    tid_d       = tid_q;
    rid_d       = rid_q;
    res_sts_d   = res_sts_q;
    res_idx_d   = res_idx_q;
    res_other_d = res_other_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_sts_d   = out_sts_q;
    out_idx_d   = out_idx_q;
    out_other_d = out_other_q;
    out_cnt_d   = out_cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = res_idx_q;
    mem_wdata   = rd_data_q;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          act_d       = req_i.action;
          tid_d       = req_i.transform_id;
          rid_d       = req_i.render_id;
          res_sts_d   = STS_OK;
          res_idx_d   = '0;
          res_other_d = '0;
          cmp_idx_d   = '0;
          state_d     = ST_RESP;
          if (req_i.action == ACT_ADD) begin
            if (cnt_q == CW'(TABLE_DEPTH)) begin
              res_sts_d = STS_FULL;
            end else begin
              // Append at the current count.
              mem_we    = 1'b1;
              mem_waddr = IW'(cnt_q);
              mem_wdata = '{transform_id: req_i.transform_id,
                            render_id:    req_i.render_id};
              res_idx_d = IW'(cnt_q);
              cnt_d     = cnt_q + CW'(1);
            end
          end else if (cnt_q == '0) begin
            res_sts_d = STS_NOT_FOUND;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (key_hit) begin
          res_idx_d   = cmp_idx_q;
          res_other_d = (act_q == ACT_FIND_R) ? rd_data_q.transform_id
                                              : rd_data_q.render_id;
          state_d     = ST_RESP;
          if (act_q == ACT_REMOVE) begin
            if (at_last) begin
              // Last entry removed: nothing to move.
              cnt_d = cnt_q - CW'(1);
            end else begin
              state_d = ST_LAST;
            end
          end
        end else if (at_last) begin
          res_sts_d = STS_NOT_FOUND;
          state_d   = ST_RESP;
        end else begin
          cmp_idx_d = IW'(cmp_idx_q + 1'b1);
        end
      end

      ST_LAST: begin
        // Read of the last pair is in flight.
        state_d = ST_MOVE;
      end

      ST_MOVE: begin
        // Move the last pair into the freed slot and shrink the table.
        mem_we    = 1'b1;
        mem_waddr = res_idx_q;
        mem_wdata = rd_data_q;
        cnt_d     = cnt_q - CW'(1);
        state_d   = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sts_d   = res_sts_q;
          out_idx_d   = IDX_W'(res_idx_q);
          out_other_d = res_other_q;
          out_cnt_d   = CNT_W'(cnt_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    act_q       <= act_d;
    tid_q       <= tid_d;
    rid_q       <= rid_d;
    res_sts_q   <= res_sts_d;
    res_idx_q   <= res_idx_d;
    res_other_q <= res_other_d;
    out_sts_q   <= out_sts_d;
    out_idx_q   <= out_idx_d;
    out_other_q <= out_other_d;
    out_cnt_q   <= out_cnt_d;
  end

  // Memory: accesses are sequenced by the state machine; where a write and a
  // read of the same entry coincide, the read data is not used.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

endmodule

// File: rtl/ipt_checker.sv
// ----------------------------------------------------------------------------
// ipt_checker
// Port-level checks of the id pair table response channel.
// ----------------------------------------------------------------------------
module ipt_checker import ipt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  status_e           status_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [ID_W-1:0]   paired_id_i,
  input  logic [CNT_W-1:0]  entry_count_i
);

  logic [CNT_W-1:0] prev_cnt_q;
  logic             out_beat;

  assign out_beat = out_valid_i && out_ready_i;

  // Track the count of the last delivered beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cnt_q <= '0;
    end else if (out_beat) begin
      prev_cnt_q <= entry_count_i;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(status_i) && $stable(entry_index_i) &&
      $stable(paired_id_i) && $stable(entry_count_i))
    else $error("response payload changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != STS_OK) |->
      (entry_index_i == '0) && (paired_id_i == '0))
    else $error("failed action returned nonzero index or id");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |->
      (entry_count_i == prev_cnt_q) ||
      (entry_count_i == prev_cnt_q + CNT_W'(1)) ||
      (entry_count_i == prev_cnt_q - CNT_W'(1)))
    else $error("pair count moved by more than one between beats");

endmodule

bind id_pair_table_swap_remove_top ipt_checker u_ipt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .entry_index_i (rsp_o.entry_index),
  .paired_id_i   (rsp_o.paired_id),
  .entry_count_i (rsp_o.entry_count)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the id pair table. Requests go in through a queue
// fed by a stimulus process, a clocked driver offers them with random gaps,
// and a clocked monitor compares every response beat with the table state
// that the bench keeps alongside the block.
// ----------------------------------------------------------------------------
module testbench import ipt_pkg::*; ();

  localparam int unsigned TABLE_DEPTH    = 1024;
  localparam int unsigned RANDOM_ITEMS   = 557;
  localparam int unsigned HOLD_AT_BEAT   = 120;   // request beat that starts the long hold
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // > worst scan + worst stall, several times
  localparam int unsigned TAIL_CYCLES    = 16;

  typedef struct {
    action_e          act;
    logic [ID_W-1:0]  tid;
    logic [ID_W-1:0]  rid;
  } table_request_t;

  typedef struct {
    status_e          status;
    logic [IDX_W-1:0] entry_index;
    logic [ID_W-1:0]  paired_id;
    logic [CNT_W-1:0] entry_count;
  } table_reply_t;

  logic clk;
  logic rst_n = 1'b0;

  ipt_req_if req_bus ();
  ipt_rsp_if rsp_bus ();

  id_pair_table_swap_remove_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Shadow of the table: the two id columns and the pair count.
  logic [ID_W-1:0] tid_col [TABLE_DEPTH];
  logic [ID_W-1:0] rid_col [TABLE_DEPTH];
  int unsigned     pairs_held = 0;

  table_request_t request_q[$];   // requests not yet offered
  table_reply_t   reply_q[$];     // replies owed by the block, oldest first

  int unsigned sent_cnt;          // request beats accepted
  int unsigned recv_cnt;          // response beats taken
  int unsigned mismatch_cnt = 0;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned quiet_cycles;

  // --------------------------------------------------------------------------
  // Clock and reset; drive every block input to a known value at time zero.
  // --------------------------------------------------------------------------
  initial begin
    clk                  = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.action       = ACT_ADD;
    req_bus.transform_id = '0;
    req_bus.render_id    = '0;
    rsp_bus.ready        = 1'b0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
      end
    join
  end

  // --------------------------------------------------------------------------
  // Table predictor: apply one action to the shadow table and return the
  // reply the block owes for it. Finds and removes hit the lowest index.
  // --------------------------------------------------------------------------
  function automatic table_reply_t table_apply(action_e act, logic [ID_W-1:0] tid,
                                               logic [ID_W-1:0] rid);
    table_reply_t r;
    int           hit;
    r.status      = STS_OK;
    r.entry_index = '0;
    r.paired_id   = '0;
    hit           = -1;
    case (act)
      ACT_ADD: begin
        if (pairs_held >= TABLE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          r.entry_index       = IDX_W'(pairs_held);
          tid_col[pairs_held] = tid;
          rid_col[pairs_held] = rid;
          pairs_held++;
        end
      end
      ACT_FIND_R: begin
        for (int i = 0; i < int'(pairs_held) && hit < 0; i++) begin
          if (rid_col[i] == rid) hit = i;
        end
        if (hit < 0) begin
          r.status = STS_NOT_FOUND;
        end else begin
          r.entry_index = IDX_W'(hit);
          r.paired_id   = tid_col[hit];
        end
      end
      default: begin  // find by transform id or remove
        for (int i = 0; i < int'(pairs_held) && hit < 0; i++) begin
          if (tid_col[i] == tid) hit = i;
        end
        if (hit < 0) begin
          r.status = STS_NOT_FOUND;
        end else begin
          r.entry_index = IDX_W'(hit);
          r.paired_id   = rid_col[hit];
          if (act == ACT_REMOVE) begin
            // Swap the last pair into the freed slot to keep the table dense.
            if (hit != int'(pairs_held) - 1) begin
              tid_col[hit] = tid_col[pairs_held-1];
              rid_col[hit] = rid_col[pairs_held-1];
            end
            pairs_held--;
          end
        end
      end
    endcase
    r.entry_count = CNT_W'(pairs_held);
    return r;
  endfunction

  // Mostly short gaps, a few long ones; one stretch in four runs flat out.
  function automatic int unsigned pick_gap(int unsigned beat_no);
    int unsigned r;
    if ((beat_no / 80) % 4 == 2) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Ids lean toward zero, all ones and a few small values so that duplicates occur.
  function automatic logic [ID_W-1:0] random_id();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return ID_W'($urandom_range(7));
      default: return ID_W'($urandom);
    endcase
  endfunction

  task automatic queue_request(action_e act, logic [ID_W-1:0] tid, logic [ID_W-1:0] rid);
    table_request_t req;
    req.act = act;
    req.tid = tid;
    req.rid = rid;
    request_q.push_back(req);
  endtask

  // Sample on the falling edge so the check never races the clocked blocks.
  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || req_bus.valid || reply_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: predict on every accepted beat, then offer the next
  // request once the current one is gone and its gap has run out.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : req_driver
    table_request_t next_req;
    if (!rst_n) begin
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACT_ADD;
      req_bus.transform_id <= '0;
      req_bus.render_id    <= '0;
      sent_cnt             <= 0;
      send_gap = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        reply_q.push_back(table_apply(req_bus.action, req_bus.transform_id,
                                      req_bus.render_id));
        sent_cnt <= sent_cnt + 1;
      end
      // Hold the beat while the block stalls; otherwise advance.
      if (!req_bus.valid || req_bus.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          req_bus.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          next_req             = request_q.pop_front();
          req_bus.valid        <= 1'b1;
          req_bus.action       <= next_req.act;
          req_bus.transform_id <= next_req.tid;
          req_bus.render_id    <= next_req.rid;
          send_gap = pick_gap(sent_cnt);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold of the response side: starts at a fixed request beat and lasts
  // long enough for the block to back up and stall its request side.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : long_hold
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_cnt == HOLD_AT_BEAT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor: check each taken beat against the oldest owed reply,
  // then decide whether to stall the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : rsp_monitor
    table_reply_t want;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      recv_cnt      <= 0;
      recv_stall = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        recv_cnt <= recv_cnt + 1;
        if (reply_q.size() == 0) begin
          $error("response beat with no request outstanding");
          mismatch_cnt++;
        end else begin
          want = reply_q.pop_front();
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
            mismatch_cnt++;
          end
          if (rsp_bus.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, actual %0d", want.entry_index,
                   rsp_bus.entry_index);
            mismatch_cnt++;
          end
          if (rsp_bus.paired_id !== want.paired_id) begin
            $error("paired_id: expected %h, actual %h", want.paired_id, rsp_bus.paired_id);
            mismatch_cnt++;
          end
          if (rsp_bus.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   rsp_bus.entry_count);
            mismatch_cnt++;
          end
        end
        recv_stall = pick_gap(recv_cnt);
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      rsp_bus.ready <= (hold_left == 0) && (recv_stall == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up when neither side moves a beat for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : watchdog
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed corner cases, then a random run over small tables.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    pair_t            known_q[$];
    pair_t            fresh;
    int unsigned      roll, add_cut, pick, est_pairs;
    bit               use_known;
    logic [ID_W-1:0]  tid, rid;

    // Empty table: every lookup misses.
    queue_request(ACT_FIND_T, 32'h0000_0000, 32'h0000_0000);
    queue_request(ACT_FIND_R, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    // Extreme and alternating ids, with a duplicate transform id.
    queue_request(ACT_ADD,    32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(ACT_ADD,    32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(ACT_ADD,    32'hAAAA_AAAA, 32'h5555_5555);
    queue_request(ACT_ADD,    32'h0000_0000, 32'h1234_5678);
    queue_request(ACT_ADD,    32'h5555_5555, 32'hAAAA_AAAA);
    // Duplicates resolve to the lowest index.
    queue_request(ACT_FIND_T, 32'h0000_0000, 32'h0000_0000);
    queue_request(ACT_FIND_R, 32'h0000_0000, 32'h0000_0000);
    queue_request(ACT_FIND_R, 32'h0000_0000, 32'h1234_5678);
    // Misses on a populated table.
    queue_request(ACT_FIND_T, 32'hDEAD_BEEF, 32'h0000_0000);
    queue_request(ACT_FIND_R, 32'h0000_0000, 32'h0BAD_F00D);
    // Removes from the middle swap the last pair in; check where it landed.
    queue_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(ACT_FIND_T, 32'h5555_5555, 32'h0000_0000);
    queue_request(ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
    queue_request(ACT_FIND_T, 32'h0000_0000, 32'h0000_0000);
    // Remove of the last entry moves nothing; then drain to empty.
    queue_request(ACT_REMOVE, 32'hAAAA_AAAA, 32'h0000_0000);
    queue_request(ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
    queue_request(ACT_REMOVE, 32'h5555_5555, 32'h0000_0000);
    queue_request(ACT_FIND_T, 32'h5555_5555, 32'h0000_0000);
    queue_request(ACT_ADD,    32'h0000_0001, 32'h0000_0002);
    queue_request(ACT_ADD,    32'h0000_0003, 32'h0000_0004);
    wait_drained();

    // Seed the key pool from the table so that most lookups hit.
    est_pairs = pairs_held;
    for (int i = 0; i < int'(pairs_held); i++) begin
      fresh.transform_id = tid_col[i];
      fresh.render_id    = rid_col[i];
      known_q.push_back(fresh);
    end

    // Random run: keep the table small so scans stay short.
    for (int n = 0; n < int'(RANDOM_ITEMS); n++) begin
      roll      = $urandom_range(99);
      add_cut   = (est_pairs > 40) ? 15 : ((est_pairs < 4) ? 60 : 35);
      use_known = (known_q.size() != 0) && ($urandom_range(3) != 0);
      pick      = use_known ? $urandom_range(known_q.size() - 1) : 0;
      tid       = random_id();
      rid       = random_id();
      if (roll < add_cut) begin
        if (use_known && $urandom_range(4) == 0) tid = known_q[pick].transform_id;
        if (use_known && $urandom_range(4) == 0) rid = known_q[pick].render_id;
        queue_request(ACT_ADD, tid, rid);
        fresh.transform_id = tid;
        fresh.render_id    = rid;
        known_q.push_back(fresh);
        est_pairs++;
      end else if (roll < add_cut + 22) begin
        if (use_known) tid = known_q[pick].transform_id;
        queue_request(ACT_FIND_T, tid, rid);
      end else if (roll < add_cut + 44) begin
        if (use_known) rid = known_q[pick].render_id;
        queue_request(ACT_FIND_R, tid, rid);
      end else begin
        if (use_known) begin
          tid = known_q[pick].transform_id;
          known_q.delete(pick);
          if (est_pairs != 0) est_pairs--;
        end
        queue_request(ACT_REMOVE, tid, rid);
      end
    end

    // Let every owed reply arrive, then watch a little longer for strays.
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
